// ===== sv/sgcm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sensor grid centroid marker.
// Depends on nothing; every other file of the block uses it.

package sgcm_pkg;

   // Intensity of a lit color channel.
   localparam logic [7:0] COLOR_FULL = 8'hff;
   // Distance past the last grid line at which an absent puck is placed.
   localparam int OFF_GRID_STEP = 2;

   typedef struct packed {
      logic [7:0] column_mask;
      logic [7:0] row_mask;
   } req_type;

   typedef struct packed {
      logic [2:0] pixel_column;
      logic [2:0] pixel_row;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [3:0] puck_column;
      logic [3:0] puck_row;
      logic       last_pixel;
   } rsp_type;

   // Puck position handed from the centroid front end to the pixel emitter.
   typedef struct packed {
      logic [3:0] puck_column;
      logic [3:0] puck_row;
   } pos_type;

   // Handshake between the front end and the position queue.
   typedef struct packed {
      logic    push;
      pos_type data;
   } push_type;

endpackage

// ===== sv/sensor_grid_centroid_marker_core.sv =====
`timescale 1ns / 1ps
// Top level of the sensor grid centroid marker.
// Depends on sgcm_pkg, sgcm_front, sgcm_queue and sgcm_back.

// A request carries one column mask and one row mask of hall sensors and is
// taken on a clock edge where start is high and busy is low. For every
// request the block sends COLUMNS*ROWS pixels, column-major with rows inner,
// one per cycle, each on rsp_data for exactly one cycle with rsp_strobe high;
// the receiver cannot stall them, so it must take every strobed pixel. Each
// pixel carries the puck centroid (the truncated mean of the set in-grid bit
// indices per axis, or COLUMNS+2 / ROWS+2 when either mask has no in-grid
// bit), red at the centroid, cyan in the one-step halo around it, and
// last_pixel on the final pixel of the run. The front end takes each request
// through accept, three divider steps and a hand-off that waits while the
// queue is full, and a two-entry position queue decouples it from the pixel
// emitter, so busy drops again long before the pixels of earlier requests are
// out. Sustained throughput is set by the emitter, which puts out one pixel a
// cycle with no gap between runs while a further position is queued.

module sensor_grid_centroid_marker_core #(
   parameter int COLUMNS = 8,
   parameter int ROWS    = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sgcm_pkg::req_type req_data,
   output logic              rsp_strobe,
   output sgcm_pkg::rsp_type rsp_data
);

   sgcm_pkg::push_type q_push;
   sgcm_pkg::pos_type  q_head;
   logic               q_full;
   logic               q_empty;
   logic               q_pop;

   // Accept the request, then divide sums by counts to get the centroid.
   sgcm_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push)
   );

   // Hold finished positions until the emitter is ready for them.
   sgcm_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .full   (q_full),
      .empty  (q_empty),
      .pop    (q_pop),
      .head   (q_head)
   );

   // Walk the grid and color each pixel against the position.
   sgcm_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (q_empty),
      .pop        (q_pop),
      .head       (q_head),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== sv/sgcm_front.sv =====
`timescale 1ns / 1ps
// Front end: takes a request, sums and counts the set mask bits, and runs
// a restoring divider per axis. Depends on sgcm_pkg.

module sgcm_front #(
   parameter int COLUMNS = 8,
   parameter int ROWS    = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sgcm_pkg::req_type req_data,
   input  logic              q_full,
   output sgcm_pkg::push_type q_push
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_PUSH   = 2'd2;

   localparam logic [3:0] OFF_COLUMN = 4'(COLUMNS + sgcm_pkg::OFF_GRID_STEP);
   localparam logic [3:0] OFF_ROW    = 4'(ROWS + sgcm_pkg::OFF_GRID_STEP);

   logic [1:0] state_ff, state_in;
   logic [1:0] step_ff, step_in;
   logic [4:0] col_rem_ff, col_rem_in, row_rem_ff, row_rem_in;
   logic [3:0] col_cnt_ff, col_cnt_in, row_cnt_ff, row_cnt_in;
   logic [2:0] col_quo_ff, col_quo_in, row_quo_ff, row_quo_in;

   logic [4:0] col_sum, row_sum;
   logic [3:0] col_num, row_num;
   logic [5:0] col_step, row_step;
   logic       accept;

   // One restoring step: returns {new remainder, quotient bit}.
   function automatic logic [5:0] div_step(input logic [4:0] rem,
                                            input logic [3:0] den,
                                            input logic [1:0] k);
      logic [6:0] trial;
      logic [6:0] wide_rem;
      trial    = 7'(den) << k;
      wide_rem = 7'(rem);
      if (wide_rem >= trial) begin
         return {5'(wide_rem - trial), 1'b1};
      end
      return {rem, 1'b0};
   endfunction

   // Sum and count the in-grid bits of both masks.
   always_comb begin
      col_sum = '0;
      row_sum = '0;
      col_num = '0;
      row_num = '0;
      for (int i = 0; i < 8; i++) begin
         if (i < COLUMNS && req_data.column_mask[i]) begin
            col_sum = col_sum + 5'(i);
            col_num = col_num + 4'd1;
         end
         if (i < ROWS && req_data.row_mask[i]) begin
            row_sum = row_sum + 5'(i);
            row_num = row_num + 4'd1;
         end
      end
   end

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign col_step = div_step(col_rem_ff, col_cnt_ff, step_ff);
   assign row_step = div_step(row_rem_ff, row_cnt_ff, step_ff);

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      col_rem_in = col_rem_ff;
      row_rem_in = row_rem_ff;
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      col_quo_in = col_quo_ff;
      row_quo_in = row_quo_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               col_rem_in = col_sum;
               row_rem_in = row_sum;
               col_cnt_in = col_num;
               row_cnt_in = row_num;
               col_quo_in = '0;
               row_quo_in = '0;
               step_in    = 2'd2;
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            col_rem_in = col_step[5:1];
            row_rem_in = row_step[5:1];
            col_quo_in = {col_quo_ff[1:0], col_step[0]};
            row_quo_in = {row_quo_ff[1:0], row_step[0]};
            step_in    = step_ff - 2'd1;
            if (step_ff == 2'd0) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!q_full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff    <= step_in;
      col_rem_ff <= col_rem_in;
      row_rem_ff <= row_rem_in;
      col_cnt_ff <= col_cnt_in;
      row_cnt_ff <= row_cnt_in;
      col_quo_ff <= col_quo_in;
      row_quo_ff <= row_quo_in;
   end

   // Drop the quotient and place the puck off grid when either mask has no in-grid bit.
   always_comb begin
      q_push.push = (state_ff == ST_PUSH) && !q_full;
      if (col_cnt_ff == 4'd0 || row_cnt_ff == 4'd0) begin
         q_push.data.puck_column = OFF_COLUMN;
         q_push.data.puck_row    = OFF_ROW;
      end else begin
         q_push.data.puck_column = {1'b0, col_quo_ff};
         q_push.data.puck_row    = {1'b0, row_quo_ff};
      end
   end

endmodule

// ===== sv/sgcm_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue of puck positions between the front end and the emitter.
// Depends on sgcm_pkg.

module sgcm_queue (
   input  logic               clock,
   input  logic               reset,
   input  sgcm_pkg::push_type q_push,
   output logic               full,
   output logic               empty,
   input  logic               pop,
   output sgcm_pkg::pos_type  head
);

   sgcm_pkg::pos_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full   = (count_ff == 2'd2);
   assign empty  = (count_ff == 2'd0);
   assign do_pop = pop && !empty;
   assign head   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ q_push.push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (q_push.push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!q_push.push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (q_push.push) begin
         entry_ff[wr_ptr_ff] <= q_push.data;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push.push |-> !full) else $error("push into a full position queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("position queue count out of range");
   a_pop_moves_count: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !q_push.push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("pop did not retire an entry");
`endif

endmodule

// ===== sv/sgcm_back.sv =====
`timescale 1ns / 1ps
// Back end: walks the grid column-major, one pixel per cycle, and colors it
// against the queued puck position. Depends on sgcm_pkg.

module sgcm_back #(
   parameter int COLUMNS = 8,
   parameter int ROWS    = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   output logic              pop,
   input  sgcm_pkg::pos_type head,
   output logic              rsp_strobe,
   output sgcm_pkg::rsp_type rsp_data
);

   localparam logic [2:0] COL_LAST = 3'(COLUMNS - 1);
   localparam logic [2:0] ROW_LAST = 3'(ROWS - 1);

   logic              active_ff, active_in;
   logic [2:0]        col_ff, col_in;
   logic [2:0]        row_ff, row_in;
   sgcm_pkg::pos_type pos_ff, pos_in;
   logic              strobe_ff, strobe_in;
   sgcm_pkg::rsp_type rsp_ff, rsp_in;
   logic              last;
   logic              col_near, row_near, center;

   function automatic logic near(input logic [2:0] a, input logic [3:0] p);
      logic [4:0] a5;
      logic [4:0] p5;
      a5 = 5'(a);
      p5 = 5'(p);
      return (a5 == p5) || (a5 + 5'd1 == p5) || (p5 + 5'd1 == a5);
   endfunction

   assign last = (col_ff == COL_LAST) && (row_ff == ROW_LAST);
   // Load the next position on the final pixel if one is queued, so runs follow without a gap.
   assign pop  = (!active_ff || last) && !empty;

   assign center   = (5'(col_ff) == 5'(pos_ff.puck_column))
                  && (5'(row_ff) == 5'(pos_ff.puck_row));
   assign col_near = near(col_ff, pos_ff.puck_column);
   assign row_near = near(row_ff, pos_ff.puck_row);

   always_comb begin
      active_in = active_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      pos_in    = pos_ff;
      if (pop) begin
         active_in = 1'b1;
         col_in    = '0;
         row_in    = '0;
         pos_in    = head;
      end else if (active_ff) begin
         if (last) begin
            active_in = 1'b0;
         end else if (row_ff == ROW_LAST) begin
            row_in = '0;
            col_in = col_ff + 3'd1;
         end else begin
            row_in = row_ff + 3'd1;
         end
      end
   end

   always_comb begin
      strobe_in           = active_ff;
      rsp_in.pixel_column = col_ff;
      rsp_in.pixel_row    = row_ff;
      rsp_in.red          = center ? sgcm_pkg::COLOR_FULL : 8'd0;
      rsp_in.green        = (!center && col_near && row_near) ? sgcm_pkg::COLOR_FULL : 8'd0;
      rsp_in.blue         = rsp_in.green;
      rsp_in.puck_column  = pos_ff.puck_column;
      rsp_in.puck_row     = pos_ff.puck_row;
      rsp_in.last_pixel   = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= strobe_in;
      end
      col_ff <= col_in;
      row_ff <= row_in;
      pos_ff <= pos_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last_pixel) |=> rsp_strobe)
      else $error("pixel run broken before its last pixel");
   a_red_excludes_halo: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.red == 8'd0 || rsp_data.green == 8'd0))
      else $error("pixel both center and halo");
   a_run_starts_at_origin: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !$past(rsp_strobe && !rsp_data.last_pixel))
      |-> (rsp_data.pixel_column == 3'd0 && rsp_data.pixel_row == 3'd0))
      else $error("pixel run did not start at the origin");
`endif

endmodule
